FILE: rtl/core/ithc_pkg.sv
// Package for the IPv4/TCP header checker: protocol codes, error codes, the
// per-packet record passed from front to back, and the one's-complement fold.
// No dependencies.
`default_nettype none

package ithc_pkg;

    // Error codes reported with each result; ERR_TOO_LONG is checked first, the rest in order of precedence.
    typedef enum logic [2:0] {
        ERR_OK             = 3'd0,
        ERR_UNDER_MIN      = 3'd1,
        ERR_UNDER_IHL      = 3'd2,
        ERR_UNDER_TOTAL    = 3'd3,
        ERR_UNDER_TCP_BASE = 3'd4,
        ERR_UNDER_TCP_HDR  = 3'd5,
        ERR_UNDER_ICMP     = 3'd6,
        ERR_TOO_LONG       = 3'd7
    } err_code_t;

    typedef enum logic [1:0] {
        PROTO_TCP   = 2'd0,
        PROTO_ICMP  = 2'd1,
        PROTO_OTHER = 2'd2
    } proto_class_t;

    localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
    localparam logic [7:0] IP_PROTO_TCP  = 8'd6;

    // Depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Everything the back end needs to finish one packet.
    typedef struct packed {
        logic [15:0]  pkt_bytes;
        logic         too_long;
        logic [3:0]   header_words;
        logic [15:0]  total_length;
        proto_class_t proto;
        logic         fragment;
        logic [3:0]   tcp_offset_words;
        logic [15:0]  header_sum;
        logic [15:0]  segment_sum;
    } pkt_rec_t;

    // End-around-carry fold of a sum of up to four 16-bit words. The result is
    // zero only when every addend was zero, which keeps it independent of the
    // order in which words were added.
    function automatic logic [15:0] oc_fold(input logic [17:0] t);
        logic [16:0] f1;
        f1 = {1'b0, t[15:0]} + {15'd0, t[17:16]};
        return f1[15:0] + {15'd0, f1[16]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ithc_if.sv
// Valid/ready channel interfaces for the packet byte stream and the results.
// Depends on nothing.
`default_nettype none

interface ithc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface ithc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  error_code;
    logic [1:0]  proto_class;
    logic        is_fragment;
    logic [5:0]  ip_header_len;
    logic [5:0]  tcp_header_len;
    logic [15:0] payload_len;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic        tcp_checksum_valid;

    modport source (
        output valid, output error_code, output proto_class, output is_fragment,
        output ip_header_len, output tcp_header_len, output payload_len,
        output ip_checksum, output tcp_checksum, output tcp_checksum_valid,
        input ready
    );
    modport sink (
        input valid, input error_code, input proto_class, input is_fragment,
        input ip_header_len, input tcp_header_len, input payload_len,
        input ip_checksum, input tcp_checksum, input tcp_checksum_valid,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/ipv4_tcp_header_check_and_checksum.sv
// IPv4/TCP header checker and checksum generator, one packet byte per cycle while the
// queue is not full. A packet's record enters the queue when its last byte is accepted,
// and moves into the output register once that register is empty or being read.
// Throughput: the front end updates its sums for each byte taken; the back end finishes
// one packet per cycle from a two-entry queue while the output register can take it.
// Reset: asynchronous, active low; clears capture state, queue and result valid at once.
`default_nettype none

module ipv4_tcp_header_check_and_checksum #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    ithc_in_if.sink     pkt_in,
    ithc_out_if.source  res_out
);

    ithc_pkg::q_status_t q_status;
    ithc_pkg::pkt_rec_t  push_data, pop_data;
    logic                push, pop;

    ithc_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_in    (pkt_in),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    ithc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    ithc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .res_out  (res_out)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ithc_front.sv
// Front end: takes packet bytes, captures header fields and accumulates the
// IP header and TCP segment one's-complement sums. Uses ithc_pkg, ithc_in_if.
`default_nettype none

module ithc_front #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic                clk,
    input  logic                rst_n,
    ithc_in_if.sink             pkt_in,
    input  ithc_pkg::q_status_t q_status,
    output logic                push,
    output ithc_pkg::pkt_rec_t  push_data
);

    localparam logic [15:0] MAX_CNT        = 16'(MAX_PACKET_BYTES);
    localparam logic [15:0] OFF_VER_IHL    = 16'd0;
    localparam logic [15:0] OFF_FIRST_LO   = 16'd1;
    localparam logic [15:0] OFF_TLEN_HI    = 16'd2;
    localparam logic [15:0] OFF_TLEN_LO    = 16'd3;
    localparam logic [15:0] OFF_TRAIL_MIN  = 16'd4;
    localparam logic [15:0] OFF_FRAG_HI    = 16'd6;
    localparam logic [15:0] OFF_FRAG_LO    = 16'd7;
    localparam logic [15:0] OFF_PROTO      = 16'd9;
    localparam logic [15:0] OFF_CSUM_HI    = 16'd10;
    localparam logic [15:0] OFF_CSUM_LO    = 16'd11;
    localparam logic [15:0] OFF_ADDR_FIRST = 16'd12;
    localparam logic [15:0] OFF_ADDR_END   = 16'd20;
    localparam logic [15:0] TCP_OFF_POS    = 16'd12;
    localparam logic [15:0] TCP_CSUM_HI    = 16'd16;
    localparam logic [15:0] TCP_CSUM_LO    = 16'd17;

    function automatic logic in_hdr(input logic [15:0] i, input logic [15:0] hlen);
        return (i < hlen) && (i != OFF_CSUM_HI) && (i != OFF_CSUM_LO);
    endfunction

    function automatic logic in_addr(input logic [15:0] i);
        return (i >= OFF_ADDR_FIRST) && (i < OFF_ADDR_END);
    endfunction

    function automatic logic in_seg(input logic [15:0] i, input logic [15:0] hlen,
                                    input logic [15:0] tlen);
        return (i >= hlen) && (i < tlen) && (i != hlen + TCP_CSUM_HI)
            && (i != hlen + TCP_CSUM_LO);
    endfunction

    logic [15:0] count_reg, count_next;
    logic        too_long_reg, too_long_next;
    logic [3:0]  hw_reg, hw_next;
    logic [15:0] tl_reg, tl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [13:0] frag_reg, frag_next;
    logic [3:0]  toff_reg, toff_next;
    logic [15:0] hs_reg, hs_next;
    logic [15:0] ss_reg, ss_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] fw_reg, fw_next;

    logic        accept;
    logic        take;
    logic        odd;
    logic [7:0]  b;
    logic [15:0] idx, hi_idx, lo_idx, base, tl_eff;
    logic [7:0]  hb;
    logic [15:0] hword, aword, sword, sword_g, fword_g;
    logic        add_en;
    logic [15:0] hs_sum, ss_sum;
    ithc_pkg::proto_class_t cls;

    assign pkt_in.ready = !q_status.full;
    assign accept       = pkt_in.valid && pkt_in.ready;
    assign push         = accept && pkt_in.last;
    assign b            = pkt_in.data_byte;

    assign idx    = count_reg;
    assign take   = count_reg < MAX_CNT;
    assign odd    = idx[0];
    assign hi_idx = {idx[15:1], 1'b0};
    assign lo_idx = {idx[15:1], 1'b1};
    assign base   = {10'd0, hw_reg, 2'b00};
    // The low length byte is only in the register after this transaction.
    assign tl_eff = (idx == OFF_TLEN_LO) ? {tl_reg[15:8], b} : tl_reg;

    // On an odd index the held byte pairs with this one; on the final even
    // index this byte is the high half of a word padded with zero.
    assign hb    = odd ? held_reg : b;
    assign hword = {in_hdr(hi_idx, base) ? hb : 8'h00,
                    (odd && in_hdr(lo_idx, base)) ? b : 8'h00};
    assign aword = {in_addr(hi_idx) ? hb : 8'h00,
                    (odd && in_addr(lo_idx)) ? b : 8'h00};
    assign sword = {in_seg(hi_idx, base, tl_eff) ? hb : 8'h00,
                    (odd && in_seg(lo_idx, base, tl_eff)) ? b : 8'h00};
    assign sword_g = (idx == OFF_FIRST_LO) ? 16'h0000 : sword;
    // The first word joins the segment sum once the total length is known.
    assign fword_g = (idx != OFF_TLEN_LO) ? 16'h0000 :
                     {in_seg(16'd0, base, tl_eff) ? fw_reg[15:8] : 8'h00,
                      in_seg(16'd1, base, tl_eff) ? fw_reg[7:0] : 8'h00};
    assign add_en = odd || (pkt_in.last && (idx >= OFF_TRAIL_MIN));

    assign hs_sum = ithc_pkg::oc_fold({2'b00, hs_reg} + {2'b00, hword});
    assign ss_sum = ithc_pkg::oc_fold({2'b00, ss_reg} + {2'b00, aword}
                                      + {2'b00, sword_g} + {2'b00, fword_g});

    always_comb
    begin
        count_next    = count_reg;
        too_long_next = too_long_reg;
        hw_next       = hw_reg;
        tl_next       = tl_reg;
        proto_next    = proto_reg;
        frag_next     = frag_reg;
        toff_next     = toff_reg;
        hs_next       = hs_reg;
        ss_next       = ss_reg;
        held_next     = held_reg;
        fw_next       = fw_reg;
        if (take)
        begin
            count_next = idx + 16'd1;
            if (idx == OFF_VER_IHL)
            begin
                hw_next = b[3:0];
            end
            if (idx == OFF_TLEN_HI)
            begin
                tl_next = {b, 8'h00};
            end
            if (idx == OFF_TLEN_LO)
            begin
                tl_next = {tl_reg[15:8], b};
            end
            if (idx == OFF_FRAG_HI)
            begin
                frag_next = {b[5:0], frag_reg[7:0]};
            end
            if (idx == OFF_FRAG_LO)
            begin
                frag_next = {frag_reg[13:8], b};
            end
            if (idx == OFF_PROTO)
            begin
                proto_next = b;
            end
            if (idx == base + TCP_OFF_POS)
            begin
                toff_next = b[7:4];
            end
            if (!odd)
            begin
                held_next = b;
            end
            if (idx == OFF_FIRST_LO)
            begin
                fw_next = {held_reg, b};
            end
            if (add_en)
            begin
                hs_next = hs_sum;
                ss_next = ss_sum;
            end
        end
        else
        begin
            too_long_next = 1'b1;
        end
    end

    always_comb
    begin
        unique case (proto_next)
            ithc_pkg::IP_PROTO_TCP:  cls = ithc_pkg::PROTO_TCP;
            ithc_pkg::IP_PROTO_ICMP: cls = ithc_pkg::PROTO_ICMP;
            default:                 cls = ithc_pkg::PROTO_OTHER;
        endcase
    end

    always_comb
    begin
        push_data.pkt_bytes        = count_next;
        push_data.too_long         = too_long_next;
        push_data.header_words     = hw_next;
        push_data.total_length     = tl_next;
        push_data.proto            = cls;
        push_data.fragment         = frag_next != 14'd0;
        push_data.tcp_offset_words = toff_next;
        push_data.header_sum       = hs_next;
        push_data.segment_sum      = ss_next;
    end

    // All capture state clears once the last byte of a packet is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            too_long_reg <= 1'b0;
            hw_reg       <= '0;
            tl_reg       <= '0;
            proto_reg    <= '0;
            frag_reg     <= '0;
            toff_reg     <= '0;
            hs_reg       <= '0;
            ss_reg       <= '0;
            held_reg     <= '0;
            fw_reg       <= '0;
        end
        else if (accept)
        begin
            if (pkt_in.last)
            begin
                count_reg    <= '0;
                too_long_reg <= 1'b0;
                hw_reg       <= '0;
                tl_reg       <= '0;
                proto_reg    <= '0;
                frag_reg     <= '0;
                toff_reg     <= '0;
                hs_reg       <= '0;
                ss_reg       <= '0;
                held_reg     <= '0;
                fw_reg       <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                too_long_reg <= too_long_next;
                hw_reg       <= hw_next;
                tl_reg       <= tl_next;
                proto_reg    <= proto_next;
                frag_reg     <= frag_next;
                toff_reg     <= toff_next;
                hs_reg       <= hs_next;
                ss_reg       <= ss_next;
                held_reg     <= held_next;
                fw_reg       <= fw_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ithc_queue.sv
// Short register queue carrying per-packet records from front to back.
// Uses ithc_pkg for the record type and depth.
`default_nettype none

module ithc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ithc_pkg::pkt_rec_t   push_data,
    input  logic                 pop,
    output ithc_pkg::pkt_rec_t   pop_data,
    output ithc_pkg::q_status_t  q_status
);

    localparam int unsigned DEPTH = ithc_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = ithc_pkg::Q_PTR_W;
    localparam int unsigned CNT_W = ithc_pkg::Q_CNT_W;

    ithc_pkg::pkt_rec_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign pop_data       = entry_reg[rd_ptr_reg];
    assign q_status.full  = count_reg == CNT_W'(DEPTH);
    assign q_status.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ithc_back.sv
// Back end: checks lengths, finishes both checksums and holds one result in
// an output register. Uses ithc_pkg and ithc_out_if.
`default_nettype none

module ithc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ithc_pkg::q_status_t q_status,
    input  ithc_pkg::pkt_rec_t  pop_data,
    output logic                pop,
    ithc_out_if.source          res_out
);

    localparam logic [15:0] MIN_IP_HDR   = 16'd20;
    localparam logic [15:0] MIN_TCP_HDR  = 16'd20;
    localparam logic [15:0] MIN_ICMP_HDR = 16'd8;

    typedef struct packed {
        ithc_pkg::err_code_t    error_code;
        ithc_pkg::proto_class_t proto_class;
        logic                   is_fragment;
        logic [5:0]             ip_header_len;
        logic [5:0]             tcp_header_len;
        logic [15:0]            payload_len;
        logic [15:0]            ip_checksum;
        logic [15:0]            tcp_checksum;
        logic                   tcp_checksum_valid;
    } res_t;

    res_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;

    ithc_pkg::err_code_t base_err;
    logic [5:0]  ihl6, thl6;
    logic [15:0] ihl16, thl16, l4_len, tcp_sum;

    assign ihl6  = {pop_data.header_words, 2'b00};
    assign thl6  = {pop_data.tcp_offset_words, 2'b00};
    assign ihl16 = {10'd0, ihl6};
    assign thl16 = {10'd0, thl6};
    assign l4_len = (pop_data.total_length > ihl16) ? pop_data.total_length - ihl16 : 16'd0;
    // Pseudo-header protocol word and TCP length join the segment sum here.
    assign tcp_sum = ithc_pkg::oc_fold({2'b00, pop_data.segment_sum}
                                       + {10'd0, ithc_pkg::IP_PROTO_TCP}
                                       + {2'b00, l4_len});

    assign pop = !q_status.empty && (!out_valid_reg || res_out.ready);

    always_comb
    begin
        if (pop_data.too_long)
        begin
            base_err = ithc_pkg::ERR_TOO_LONG;
        end
        else if (pop_data.pkt_bytes < MIN_IP_HDR)
        begin
            base_err = ithc_pkg::ERR_UNDER_MIN;
        end
        else if (pop_data.pkt_bytes < ihl16)
        begin
            base_err = ithc_pkg::ERR_UNDER_IHL;
        end
        else if (pop_data.pkt_bytes < pop_data.total_length)
        begin
            base_err = ithc_pkg::ERR_UNDER_TOTAL;
        end
        else
        begin
            base_err = ithc_pkg::ERR_OK;
        end
    end

    always_comb
    begin
        res_next                    = '0;
        res_next.error_code         = base_err;
        res_next.proto_class        = ithc_pkg::PROTO_TCP;
        if (base_err == ithc_pkg::ERR_OK)
        begin
            res_next.proto_class   = pop_data.proto;
            res_next.is_fragment   = pop_data.fragment;
            res_next.ip_header_len = ihl6;
            res_next.ip_checksum   = ~pop_data.header_sum;
            if (!pop_data.fragment)
            begin
                if (pop_data.proto == ithc_pkg::PROTO_TCP)
                begin
                    if (pop_data.pkt_bytes < ihl16 + MIN_TCP_HDR)
                    begin
                        res_next.error_code = ithc_pkg::ERR_UNDER_TCP_BASE;
                    end
                    else if (pop_data.pkt_bytes < ihl16 + thl16)
                    begin
                        res_next.error_code = ithc_pkg::ERR_UNDER_TCP_HDR;
                    end
                    else
                    begin
                        res_next.tcp_header_len     = thl6;
                        res_next.payload_len        = pop_data.pkt_bytes - ihl16 - thl16;
                        res_next.tcp_checksum       = ~tcp_sum;
                        res_next.tcp_checksum_valid = 1'b1;
                    end
                end
                else if (pop_data.proto == ithc_pkg::PROTO_ICMP
                         && pop_data.pkt_bytes < ihl16 + MIN_ICMP_HDR)
                begin
                    res_next.error_code = ithc_pkg::ERR_UNDER_ICMP;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign res_out.valid              = out_valid_reg;
    assign res_out.error_code         = res_reg.error_code;
    assign res_out.proto_class        = res_reg.proto_class;
    assign res_out.is_fragment        = res_reg.is_fragment;
    assign res_out.ip_header_len      = res_reg.ip_header_len;
    assign res_out.tcp_header_len     = res_reg.tcp_header_len;
    assign res_out.payload_len        = res_reg.payload_len;
    assign res_out.ip_checksum        = res_reg.ip_checksum;
    assign res_out.tcp_checksum       = res_reg.tcp_checksum;
    assign res_out.tcp_checksum_valid = res_reg.tcp_checksum_valid;

endmodule

`default_nettype wire

FILE: rtl/core/ithc_checker.sv
// Port-level checker for the header checker's result channel, bound to the
// top level. Uses ithc_pkg for error and protocol codes.
`default_nettype none

module ithc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  error_code,
    input logic [1:0]  proto_class,
    input logic        is_fragment,
    input logic [5:0]  ip_header_len,
    input logic [5:0]  tcp_header_len,
    input logic [15:0] payload_len,
    input logic [15:0] ip_checksum,
    input logic [15:0] tcp_checksum,
    input logic        tcp_checksum_valid
);

    // A stalled result transaction stays valid and keeps its checksums and error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ip_checksum)
            && $stable(tcp_checksum) && $stable(error_code))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tcp_checksum_valid |->
            error_code == ithc_pkg::ERR_OK && proto_class == ithc_pkg::PROTO_TCP
            && !is_fragment)
        else $error("TCP checksum flagged valid on a non-TCP or failing packet");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tcp_checksum_valid |->
            tcp_header_len == 6'd0 && payload_len == 16'd0 && tcp_checksum == 16'd0)
        else $error("TCP fields set without a valid TCP checksum");

    // Errors found before classification leave the IP fields cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code == ithc_pkg::ERR_UNDER_MIN
            || error_code == ithc_pkg::ERR_UNDER_IHL
            || error_code == ithc_pkg::ERR_UNDER_TOTAL
            || error_code == ithc_pkg::ERR_TOO_LONG) |->
            proto_class == 2'd0 && !is_fragment && ip_header_len == 6'd0
            && ip_checksum == 16'd0)
        else $error("IP fields set on a length error");

endmodule

bind ipv4_tcp_header_check_and_checksum ithc_checker u_ithc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (res_out.valid),
    .out_ready          (res_out.ready),
    .error_code         (res_out.error_code),
    .proto_class        (res_out.proto_class),
    .is_fragment        (res_out.is_fragment),
    .ip_header_len      (res_out.ip_header_len),
    .tcp_header_len     (res_out.tcp_header_len),
    .payload_len        (res_out.payload_len),
    .ip_checksum        (res_out.ip_checksum),
    .tcp_checksum       (res_out.tcp_checksum),
    .tcp_checksum_valid (res_out.tcp_checksum_valid)
);

`default_nettype wire
